>>> hw/rtl/itf_pkg.sv
// Package for the integer to text formatter: widths, character codes,
// controller/datapath command and status types, digit-to-ASCII helper.
// No dependencies.
`default_nettype none

package itf_pkg;

  // Width of the converted value and of the value field on the port
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IN_W        = 32;

  // ASCII codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;

  // Conversion handles four magnitude bits per cycle
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int unsigned MAG_W         = STEPS * BITS_PER_STEP;
  localparam int unsigned STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Digit buffer: enough decimal digits for 2^VALUE_WIDTH - 1 (log10(2) ~ 0.30103)
  localparam int unsigned DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int unsigned BCD_W      = NDIG * 4;
  localparam int unsigned IDX_W      = (NDIG > 1) ? $clog2(NDIG) : 1;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture input item
    logic step;        // one conversion step
    logic set_idx;     // point at the most significant nonzero digit
    logic emit_sign;   // write '-' to the output register
    logic emit_digit;  // write current digit, move down one place
  } itf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hex;         // selector of the item on the input port
    logic neg;         // captured item is negative
    logic conv_last;   // this is the final conversion step
    logic idx_zero;    // current digit is the least significant one
    logic slot_free;   // output register can take a character this cycle
  } itf_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = CH_ZERO + {4'b0000, d};
    else           c = CH_A + {4'b0000, d - 4'd10};
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/itf_ctrl.sv
// Controller of the integer to text formatter: one-hot sequencer that
// drives the datapath. Depends on itf_pkg.
`default_nettype none

module itf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  itf_pkg::itf_sts_t sts_i,
  output itf_pkg::itf_cmd_t cmd_o
);
  import itf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_PREP  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.hex ? S_PREP : S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (sts_i.conv_last) state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.set_idx = 1'b1;
        state_d       = sts_i.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.idx_zero) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/itf_dp.sv
// Datapath of the integer to text formatter: magnitude and BCD registers
// (shift-add-3 conversion), digit pointer and output register. Depends on itf_pkg.
`default_nettype none

module itf_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  itf_pkg::itf_cmd_t       cmd_i,
  output itf_pkg::itf_sts_t       sts_o,
  input  logic                    func_i,
  input  logic [itf_pkg::IN_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              char_code_o,
  output logic                    last_o
);
  import itf_pkg::*;

  logic [MAG_W-1:0]           mag_q, mag_step;
  logic [NDIG-1:0][3:0]       bcd_q, bcd_step, bcd_load;
  logic                       neg_q;
  logic [STEP_W-1:0]          cnt_q;
  logic [IDX_W-1:0]           idx_q, idx_top;
  logic                       ovalid_q;
  logic [7:0]                 char_q;
  logic                       last_q;

  logic [VALUE_WIDTH-1:0]     v_in, mag_in;
  logic                       neg_in;
  logic [NDIG-1:0][3:0]       b;
  logic [MAG_W-1:0]           m;

  // Input capture: sign and magnitude without overflow
  assign v_in     = VALUE_WIDTH'(value_i);
  assign neg_in   = !func_i && v_in[VALUE_WIDTH-1];
  assign mag_in   = neg_in ? (~v_in + 1'b1) : v_in;
  assign bcd_load = func_i ? BCD_W'(v_in) : '0;

  // Four shift-add-3 steps per cycle
  always_comb begin
    b = bcd_q;
    m = mag_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int k = 0; k < NDIG; k++) begin
        if (b[k] >= 4'd5) b[k] = b[k] + 4'd3;
      end
      b = BCD_W'({b, m[MAG_W-1]});
      m = m << 1;
    end
    bcd_step = b;
    mag_step = m;
  end

  // Most significant nonzero digit, zero if all digits are zero
  always_comb begin
    idx_top = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_q[k] != 4'd0) idx_top = IDX_W'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= MAG_W'(mag_in);
      bcd_q <= bcd_load;
      neg_q <= neg_in;
    end else if (cmd_i.step) begin
      mag_q <= mag_step;
      bcd_q <= bcd_step;
    end
    if (cmd_i.set_idx) begin
      idx_q <= idx_top;
    end else if (cmd_i.emit_digit) begin
      idx_q <= idx_q - 1'b1;
    end
    if (cmd_i.emit_sign) begin
      char_q <= CH_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= digit_char(bcd_q[idx_q]);
      last_q <= (idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.load)      cnt_q <= '0;
      else if (cmd_i.step) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.emit_sign || cmd_i.emit_digit) ovalid_q <= 1'b1;
      else if (out_ready_i)                     ovalid_q <= 1'b0;
    end
  end

  assign sts_o.hex       = func_i;
  assign sts_o.neg       = neg_q;
  assign sts_o.conv_last = (cnt_q == STEP_W'(STEPS - 1));
  assign sts_o.idx_zero  = (idx_q == '0);
  assign sts_o.slot_free = !ovalid_q || out_ready_i;

  assign out_valid_o = ovalid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> hw/rtl/integer_to_text_formatter.sv
// Integer to text formatter: signed decimal or lowercase hex ASCII, one char per item out.
// Before the first char: decimal runs load, conversion steps, prep; hex runs load, prep.
// Throughput: one char per cycle when drained; a value occupies the block until its
//   last char has been written to the output register.
// Speed set by the four-bit-per-cycle shift-add-3 BCD loop in itf_dp.
// Reset (async, active low) returns the sequencer to idle and empties the output register.
`default_nettype none

module integer_to_text_formatter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     func_i,
  input  logic [itf_pkg::IN_W-1:0] value_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               char_code_o,
  output logic                     last_o
);
  import itf_pkg::*;

  itf_cmd_t cmd;
  itf_sts_t sts;

  // Sequencer: idle -> convert (decimal only) -> prep -> sign (negative only) -> digits.
  // A new item is taken only in idle, so the last char of the previous item may
  // still sit in the output register while the next value is loaded.
  itf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: magnitude/BCD registers, digit pointer, output register.
  // Hex mode loads the nibbles straight into the digit buffer.
  itf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/itf_checker.sv
// Port-level assertions for the integer to text formatter, bound to the top level.
// Depends on itf_pkg and integer_to_text_formatter.
`default_nettype none

module itf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] char_code_o,
  input logic       last_o
);
  import itf_pkg::*;

  // Stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_code_o) && $stable(last_o))
    else $error("output item changed while stalled");

  // One value at a time: no back-to-back accepts
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted in consecutive cycles");

  // Only legal characters leave the block
  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == CH_MINUS) ||
                    (char_code_o >= CH_ZERO && char_code_o <= CH_ZERO + 8'd9) ||
                    (char_code_o >= CH_A && char_code_o <= CH_A + 8'd5))
    else $error("illegal character code");

  // A sign is never marked as the last character
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (char_code_o == CH_MINUS) |-> !last_o)
    else $error("minus sign marked last");

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .char_code_o (char_code_o),
  .last_o      (last_o)
);

`default_nettype wire

>>> tb/itf_test_pkg.sv
// Shared testbench codes for the integer to text formatter bench.
// Holds the format selector names; no dependencies.
package itf_test_pkg;

  typedef enum logic {
    FMT_DEC = 1'b0,  // signed decimal
    FMT_HEX = 1'b1   // unsigned lowercase hex
  } fmt_e;

endpackage

>>> tb/itf_text_checker.sv
// Checker for the integer to text formatter: predicts the characters of each
// accepted value and compares the output stream. Needs itf_pkg, itf_test_pkg.
module itf_text_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     func_i,
  input  logic [itf_pkg::IN_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [7:0]               char_code_i,
  input  logic                     last_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       chars_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import itf_pkg::*;
  import itf_test_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  text_char_t expected_chars[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
    chars_o   = 0;
  end

  // Appends the characters of one value, most significant first.
  function automatic void predict_text(input fmt_e fmt, input logic [IN_W-1:0] raw);
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] rem;
    logic [7:0]             digits[$];
    logic [3:0]             nib;
    logic                   neg;
    text_char_t             c;
    mag = raw[VALUE_WIDTH-1:0];
    neg = 1'b0;
    if (fmt == FMT_HEX) begin
      do begin
        nib = mag[3:0];
        digits.push_front((nib < 4'd10) ? CH_ZERO + nib : CH_A + (nib - 4'd10));
        mag = mag >> 4;
      end while (mag != '0);
    end else begin
      neg = mag[VALUE_WIDTH-1];
      // two's complement negate; the most negative value maps onto itself,
      // which read as unsigned is exactly its magnitude
      if (neg) mag = ~mag + 1'b1;
      do begin
        rem = mag % 10;
        digits.push_front(CH_ZERO + rem[7:0]);
        mag = mag / 10;
      end while (mag != '0);
    end
    if (neg) begin
      c.code = CH_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = 0; i < digits.size(); i++) begin
      c.code = digits[i];
      c.last = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void report(input string what, input int exp_v, input int act_v);
    errors_o++;
    $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
  endfunction

  // Output side is handled before the input side so that a character can
  // never be matched against a value accepted on the same edge.
  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        chars_o++;
        if (expected_chars.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected char: expected none, got %h last %b",
                   $time, char_code_i, last_i);
        end else begin
          exp_c = expected_chars.pop_front();
          if (char_code_i !== exp_c.code) report("char_code", exp_c.code, char_code_i);
          if (last_i !== exp_c.last) report("last", exp_c.last, last_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_text(fmt_e'(func_i), value_i);
      pending_o = expected_chars.size();
    end
  end

endmodule

>>> tb/integer_to_text_formatter_test.sv
// Top of the integer to text formatter bench: clock, reset, stimulus, flow
// control and verdict. Needs itf_pkg, itf_test_pkg, itf_text_checker and the RTL.
module integer_to_text_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import itf_pkg::*;
  import itf_test_pkg::*;

  // Longest legal quiet stretch is the output hold-off (HOLD_CYCLES) plus a
  // conversion and a few random gaps; the limit is far above that.
  localparam int STALL_LIMIT      = 2000;
  localparam int HOLD_CYCLES      = 80;
  localparam int RANDOM_PER_PHASE = 53;
  localparam int DRAIN_CYCLES     = 30;   // beyond the worst case for one value

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  logic            func_i      = 1'b0;
  logic [IN_W-1:0] value_i     = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [7:0]      char_code_o;
  logic            last_o;

  int errors;
  int pending;
  int chars_checked;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;   // set by stimulus, taken up by the receiver
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int dec_values    = 0;
  int hex_values    = 0;

  integer_to_text_formatter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  itf_text_checker text_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_i (char_code_o),
    .last_i      (last_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .chars_o     (chars_checked)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, or a counted hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offers one item, with a random gap first; returns at the falling edge
  // after acceptance. Valid stays high into the next item when there is no gap.
  task automatic send_value(input fmt_e fmt, input logic [IN_W-1:0] value);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i     = fmt;
    value_i    = value;
    if (fmt == FMT_HEX) hex_values++;
    else dec_values++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mix of short, full-width, negative and extreme values; short ones keep
  // the digit count spread across 1..11 characters.
  task automatic send_random();
    fmt_e            fmt;
    logic [IN_W-1:0] v;
    int              w;
    fmt = $urandom_range(1, 0) ? FMT_HEX : FMT_DEC;
    case ($urandom_range(7, 0))
      0: v = $urandom_range(20, 0);
      1: v = -$urandom_range(20, 1);
      2: begin
        case ($urandom_range(3, 0))
          0: v = 32'h0000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h8000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      3: v = $urandom;
      default: begin
        w = $urandom_range(32, 1);
        v = $urandom >> (32 - w);
        if (fmt == FMT_DEC && $urandom_range(1, 0)) v = -v;
      end
    endcase
    send_value(fmt, v);
  endtask

  // Sender pause: nothing offered until every expected character is out.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      // idle profiles: sender-light/receiver-heavy, swapped, then none
      case (phase)
        0: begin send_idle_pct = 38; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (phase == 0) begin
        // zero, single digits, carries across a power of ten
        send_value(FMT_DEC, 32'd0);
        send_value(FMT_DEC, 32'd1);
        send_value(FMT_DEC, 32'd9);
        send_value(FMT_DEC, 32'd10);
        send_value(FMT_DEC, 32'd1_000_000_000);
        send_value(FMT_DEC, 32'd4_000_000_000);   // reads as a negative
        // largest positive, minus one, minus ten
        send_value(FMT_DEC, 32'h7fff_ffff);
        send_value(FMT_DEC, 32'hffff_ffff);
        send_value(FMT_DEC, -32'sd10);
        // most negative value and its neighbor
        send_value(FMT_DEC, 32'h8000_0000);
        send_value(FMT_DEC, 32'h8000_0001);
        // hex: zero, nine/ten boundary, every letter, full width
        send_value(FMT_HEX, 32'h0);
        send_value(FMT_HEX, 32'h9);
        send_value(FMT_HEX, 32'ha);
        send_value(FMT_HEX, 32'hf);
        send_value(FMT_HEX, 32'h10);
        send_value(FMT_HEX, 32'habcd_ef01);
        send_value(FMT_HEX, 32'h1234_5678);
        send_value(FMT_HEX, 32'h8000_0000);
        send_value(FMT_HEX, 32'hffff_ffff);
        send_value(FMT_HEX, 32'h7fff_ffff);
      end

      // long output hold-off with the sender pushing back-to-back, so the
      // block fills up and has to drop in_ready
      if (phase == 2) hold_request = HOLD_CYCLES;

      repeat (RANDOM_PER_PHASE) send_random();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d decimal and %0d hex values, %0d characters checked,",
             dec_values, hex_values, chars_checked);
    $display("under three idle profiles and an %0d-cycle output hold-off.", HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
